// File: rtl/zoned_motor_pattern_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Zoned motor pattern controller assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef ZONED_MOTOR_PATTERN_CONTROLLER_UNIT_DEFINES_SVH
`define ZONED_MOTOR_PATTERN_CONTROLLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZMPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/zmpc_pkg.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller package
// Shared constants, command codes, the decoded operation and back-end state
// types and the duty scaling function.
// ----------------------------------------------------------------------------
`default_nettype none

package zmpc_pkg;

    localparam int MOTOR_COUNT      = 10;
    localparam int TICKS_PER_MINUTE = 60000;

    localparam int CNT_W         = $clog2(MOTOR_COUNT);
    localparam int MOTOR_INDEX_W = 4;
    localparam int PCT_W         = 7;
    localparam int MINUTES_MIN   = 5;
    localparam int MINUTES_MAX   = 120;
    localparam int MINUTES_RESET = 10;
    localparam int PCT_MAX       = 100;
    localparam int ELAPSED_W     = $clog2(MINUTES_MAX * TICKS_PER_MINUTE + 1);
    localparam int PATTERN_W     = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0]           PRESET_NONE   = 8'd255;
    localparam logic [7:0]           PRESET_WAVE   = 8'd0;
    localparam logic [7:0]           PRESET_PULSE  = 8'd1;
    localparam logic [7:0]           PRESET_RIPPLE = 8'd2;
    localparam logic [PATTERN_W-1:0] PATTERN_READY = PATTERN_W'(600);
    localparam logic [PATTERN_W-1:0] PERIOD_WAVE   = PATTERN_W'(600);
    localparam logic [PATTERN_W-1:0] PERIOD_PULSE  = PATTERN_W'(500);
    localparam logic [PATTERN_W-1:0] PERIOD_RIPPLE = PATTERN_W'(450);

    localparam logic [PCT_W-1:0] PCT_WAVE_PEAK  = PCT_W'(80);
    localparam logic [PCT_W-1:0] PCT_WAVE_NEAR  = PCT_W'(45);
    localparam logic [PCT_W-1:0] PCT_WAVE_FAR   = PCT_W'(15);
    localparam logic [PCT_W-1:0] PCT_PULSE_ON   = PCT_W'(70);
    localparam logic [PCT_W-1:0] PCT_RIPPLE_HI  = PCT_W'(70);
    localparam logic [PCT_W-1:0] PCT_RIPPLE_LO  = PCT_W'(10);

    // pct * 255 / 100 == (pct * 255 * 5243) >> 19 for every pct up to 100.
    localparam logic [20:0] DUTY_RECIP = 21'd1336965;
    localparam int          DUTY_SHIFT = 19;

    localparam logic [2:0] CMD_OFF     = 3'd0;
    localparam logic [2:0] CMD_ALL     = 3'd1;
    localparam logic [2:0] CMD_PAIR    = 3'd2;
    localparam logic [2:0] CMD_SINGLE  = 3'd3;
    localparam logic [2:0] CMD_PATTERN = 3'd4;
    localparam logic [2:0] CMD_SESSION = 3'd5;
    localparam logic [2:0] CMD_TICK    = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_OFF,
        OP_LEVEL,
        OP_PRESET,
        OP_TIMER,
        OP_TICK
    } op_kind_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [MOTOR_COUNT-1:0]  mask;
        logic [PCT_W-1:0]        val;
        logic [7:0]              preset;
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    function automatic logic [7:0] duty_of(input logic [PCT_W-1:0] pct);
        logic [27:0] prod;
        prod = 28'(pct) * 28'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// File: rtl/zmpc_front.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller front end
// Holds the bed address, accepts input beats and turns them into decoded
// operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module zmpc_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [7:0]                     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [zmpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [zmpc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                op_valid,
    input  wire logic                           op_ready,
    output zmpc_pkg::op_t                       op
);
    import zmpc_pkg::*;

    logic [7:0] bed_address_reg;
    logic [7:0] bed_id;
    logic [7:0] target;
    logic [7:0] value;
    logic       bed_ok;
    logic [PCT_W-1:0] pct;
    logic [PCT_W-1:0] minutes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bed_address_reg <= 8'd1;
        end else if (cfg_we) begin
            bed_address_reg <= cfg_wdata;
        end
    end

    assign bed_id   = s_tdata[7:0];
    assign target   = s_tdata[15:8];
    assign value    = s_tdata[23:16];
    assign bed_ok   = (bed_id == bed_address_reg);
    assign s_tready = op_ready;
    assign op_valid = s_tvalid;

    always_comb begin
        if (value > 8'(PCT_MAX)) begin
            pct = PCT_W'(PCT_MAX);
        end else begin
            pct = value[PCT_W-1:0];
        end
        if (value < 8'(MINUTES_MIN)) begin
            minutes = PCT_W'(MINUTES_MIN);
        end else if (value > 8'(MINUTES_MAX)) begin
            minutes = PCT_W'(MINUTES_MAX);
        end else begin
            minutes = value[PCT_W-1:0];
        end
    end

    always_comb begin
        op.kind   = OP_NOP;
        op.mask   = '0;
        op.val    = pct;
        op.preset = target;
        if (s_tuser == CMD_TICK) begin
            op.kind = OP_TICK;
        end else if (bed_ok) begin
            unique case (s_tuser)
                CMD_OFF: begin
                    op.kind = OP_OFF;
                end
                CMD_ALL: begin
                    op.kind = OP_LEVEL;
                    op.mask = '1;
                end
                CMD_PAIR: begin
                    // Out-of-range zones leave the operation as a no-op.
                    if (target < 8'(MOTOR_COUNT / 2)) begin
                        op.kind = OP_LEVEL;
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            op.mask[i] = (8'(i >> 1) == target);
                        end
                    end
                end
                CMD_SINGLE: begin
                    if (target < 8'(MOTOR_COUNT)) begin
                        op.kind = OP_LEVEL;
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            op.mask[i] = (8'(i) == target);
                        end
                    end
                end
                CMD_PATTERN: begin
                    op.kind = OP_PRESET;
                end
                CMD_SESSION: begin
                    op.kind = OP_TIMER;
                    op.val  = minutes;
                end
                default: begin
                    op.kind = OP_NOP;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/zmpc_queue.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller operation queue
// A short first-in first-out queue of decoded operations between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module zmpc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  zmpc_pkg::op_t      in_op,
    output logic               out_valid,
    input  wire logic          out_ready,
    output zmpc_pkg::op_t      out_op
);
    import zmpc_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/zmpc_back.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller back end
// Applies one decoded operation to the motor and session state, then sends
// one result beat per motor through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module zmpc_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           op_valid,
    output logic                                op_ready,
    input  zmpc_pkg::op_t                       op,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [zmpc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import zmpc_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [PCT_W-1:0]       drive_reg [MOTOR_COUNT];
    logic [PCT_W-1:0]       drive_next [MOTOR_COUNT];
    logic [7:0]             preset_reg;
    logic [7:0]             preset_next;
    logic [PCT_W-1:0]       minutes_reg;
    logic [PCT_W-1:0]       minutes_next;
    logic                   enabled_reg;
    logic                   enabled_next;
    logic                   session_reg;
    logic                   session_next;
    logic [ELAPSED_W-1:0]   elapsed_reg;
    logic [ELAPSED_W-1:0]   elapsed_next;
    logic [ELAPSED_W-1:0]   limit_reg;
    logic [PATTERN_W-1:0]   pat_reg;
    logic [PATTERN_W-1:0]   pat_next;
    logic [CNT_W-1:0]       step_reg;
    logic [CNT_W-1:0]       step_next;

    logic                     m_valid_reg;
    logic [MOTOR_INDEX_W-1:0] out_idx_reg;
    logic [7:0]               out_duty_reg;
    logic                     out_last_reg;
    logic                     out_run_reg;
    logic                     out_act_reg;
    logic [7:0]               out_preset_reg;
    logic [PCT_W-1:0]         out_minutes_reg;

    logic                   out_free;
    logic                   adv;
    logic                   last_load;
    logic                   pop;
    logic                   cnt_at_last;

    logic                   pattern_known;
    logic [PATTERN_W-1:0]   period;
    logic [PATTERN_W-1:0]   pat_inc;
    logic [CNT_W:0]         step_inc;
    logic [ELAPSED_W-1:0]   elapsed_inc;

    assign out_free    = !m_valid_reg || m_tready;
    assign cnt_at_last = (cnt_reg == CNT_W'(MOTOR_COUNT - 1));

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (op_valid) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free && cnt_at_last && !op_valid) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer: outputs. The next operation is applied in the same cycle the
    // last result of the current one is loaded, since that load reads the old
    // state.
    always_comb begin
        adv       = 1'b0;
        last_load = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                adv = 1'b0;
            end
            BK_EMIT: begin
                adv       = out_free;
                last_load = out_free && cnt_at_last;
            end
            default: begin
                adv = 1'b0;
            end
        endcase
        pop = op_valid && ((state_reg == BK_IDLE) || last_load);
    end

    assign op_ready = pop;

    always_comb begin
        pattern_known = 1'b1;
        unique case (preset_reg)
            PRESET_WAVE:   period = PERIOD_WAVE;
            PRESET_PULSE:  period = PERIOD_PULSE;
            PRESET_RIPPLE: period = PERIOD_RIPPLE;
            default: begin
                period        = PERIOD_WAVE;
                pattern_known = 1'b0;
            end
        endcase
    end

    assign pat_inc     = (pat_reg < PATTERN_READY) ? pat_reg + 1'b1 : pat_reg;
    assign step_inc    = {1'b0, step_reg} + 1'b1;
    assign elapsed_inc = elapsed_reg + 1'b1;

    always_comb begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            drive_next[i] = drive_reg[i];
        end
        preset_next  = preset_reg;
        minutes_next = minutes_reg;
        enabled_next = enabled_reg;
        session_next = session_reg;
        elapsed_next = elapsed_reg;
        pat_next     = pat_reg;
        step_next    = step_reg;
        unique case (op.kind)
            OP_NOP: begin
                preset_next = preset_reg;
            end
            OP_OFF: begin
                preset_next = PRESET_NONE;
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    drive_next[i] = '0;
                end
                session_next = 1'b0;
                enabled_next = 1'b1;
            end
            OP_LEVEL: begin
                preset_next = PRESET_NONE;
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    if (op.mask[i]) begin
                        drive_next[i] = op.val;
                    end
                end
                session_next = 1'b1;
                enabled_next = 1'b1;
                elapsed_next = '0;
            end
            OP_PRESET: begin
                preset_next  = op.preset;
                step_next    = '0;
                pat_next     = PATTERN_READY;
                session_next = 1'b1;
                enabled_next = 1'b1;
                elapsed_next = '0;
            end
            OP_TIMER: begin
                minutes_next = op.val;
                if (session_reg) begin
                    elapsed_next = '0;
                end
            end
            OP_TICK: begin
                if (enabled_reg && pattern_known) begin
                    if (pat_inc >= period) begin
                        pat_next = '0;
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            if (preset_reg == PRESET_WAVE) begin
                                if ((CNT_W + 1)'(i) == {1'b0, step_reg}) begin
                                    drive_next[i] = PCT_WAVE_PEAK;
                                end else if (((CNT_W + 1)'(i) == step_inc) ||
                                             ((CNT_W + 1)'(i + 1) == {1'b0, step_reg})) begin
                                    drive_next[i] = PCT_WAVE_NEAR;
                                end else begin
                                    drive_next[i] = PCT_WAVE_FAR;
                                end
                            end else if (preset_reg == PRESET_PULSE) begin
                                drive_next[i] = step_reg[0] ? PCT_PULSE_ON : '0;
                            end else begin
                                drive_next[i] = ((1'(i) ^ step_reg[0]) == 1'b0) ?
                                                PCT_RIPPLE_HI : PCT_RIPPLE_LO;
                            end
                        end
                        if (preset_reg == PRESET_WAVE) begin
                            step_next = (step_inc >= (CNT_W + 1)'(MOTOR_COUNT)) ?
                                        '0 : step_inc[CNT_W-1:0];
                        end else begin
                            step_next = CNT_W'(~step_reg[0]);
                        end
                    end else begin
                        pat_next = pat_inc;
                    end
                end
                if (session_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit_reg) begin
                        enabled_next = 1'b0;
                        session_next = 1'b0;
                        for (int i = 0; i < MOTOR_COUNT; i++) begin
                            drive_next[i] = '0;
                        end
                    end
                end
            end
            default: begin
                preset_next = preset_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            preset_reg  <= PRESET_NONE;
            minutes_reg <= PCT_W'(MINUTES_RESET);
            enabled_reg <= 1'b1;
            session_reg <= 1'b1;
            elapsed_reg <= '0;
            limit_reg   <= ELAPSED_W'(MINUTES_RESET * TICKS_PER_MINUTE);
            pat_reg     <= PATTERN_READY;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                drive_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // The limit follows a minutes change in the cycle after; no tick can be
            // applied that soon after the timer command.
            limit_reg <= ELAPSED_W'(minutes_reg * TICKS_PER_MINUTE);
            if (pop) begin
                cnt_reg     <= '0;
                preset_reg  <= preset_next;
                minutes_reg <= minutes_next;
                enabled_reg <= enabled_next;
                session_reg <= session_next;
                elapsed_reg <= elapsed_next;
                pat_reg     <= pat_next;
                step_reg    <= step_next;
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    drive_reg[i] <= drive_next[i];
                end
            end else if (adv) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_idx_reg     <= MOTOR_INDEX_W'(cnt_reg);
            out_duty_reg    <= duty_of(drive_reg[cnt_reg]);
            out_last_reg    <= cnt_at_last;
            out_run_reg     <= session_reg;
            out_act_reg     <= enabled_reg;
            out_preset_reg  <= preset_reg;
            out_minutes_reg <= minutes_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_minutes_reg, out_preset_reg, out_act_reg,
                       out_run_reg, out_duty_reg, out_idx_reg};

endmodule

`default_nettype wire

// File: rtl/zoned_motor_pattern_controller_unit.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller
// Ten-motor drive level controller with manual levels, preset patterns and a
// session timer, on stream-style input and result channels.
// ----------------------------------------------------------------------------
// Each input beat is a bed command or a one-millisecond tick, and each one
// produces exactly ten result beats, one per motor in ascending order, with
// m_tlast on the tenth. The result serializer in the back end sends one motor
// per cycle while m_tready is held high, and it takes the next item only with
// the last result of the current one; each item is registered in the queue,
// applied to the back-end state when popped, and sent through the output register.
// The front end decodes and range-checks beats into a two-entry queue, so up
// to two further items are taken while results are still draining. The bed
// address register is written through cfg_we/cfg_wdata and must only change
// while no item is in flight. Duty is reported as percent * 255 / 100,
// rounded down; active_preset reads 255 while manual levels are in force.
// ----------------------------------------------------------------------------
`default_nettype none

module zoned_motor_pattern_controller_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Bed address register write.
    input  wire logic                           cfg_we,
    input  wire logic [7:0]                     cfg_wdata,
    // Input channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata, low bit up: bed_id[7:0], target[15:8], value[23:16].
    input  wire logic [zmpc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser, low bit up: cmd[2:0].
    input  wire logic [zmpc_pkg::S_TUSER_W-1:0] s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata, low bit up: motor_index[3:0], duty[11:4], session_running[12],
    // output_active[13], active_preset[21:14], session_minutes[28:22],
    // zero[31:29].
    output logic [zmpc_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tlast: last_motor, set on the final motor of each item.
    output logic                                m_tlast
);
    import zmpc_pkg::*;

    // Decoded operations flow front -> queue -> back.
    op_t  front_op;
    logic front_valid;
    logic front_ready;
    op_t  back_op;
    logic back_valid;
    logic back_ready;

    // The front end owns the bed address and classifies every beat; commands
    // for another bed, unused codes and out-of-range targets become no-ops so
    // that they still yield their ten results.
    zmpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    // The queue lets the front keep taking beats while the back end drains.
    zmpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_op    (back_op)
    );

    // The back end holds all motor, pattern and session state, applies each
    // popped operation to that state and then streams the per-motor results.
    zmpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (back_valid),
        .op_ready  (back_ready),
        .op        (back_op),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/zmpc_checker.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zoned_motor_pattern_controller_unit_defines.svh"

module zmpc_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [zmpc_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                           m_tlast
);
    import zmpc_pkg::*;

    logic [MOTOR_INDEX_W-1:0] exp_idx_reg;

    // Tracks which motor the next result beat must describe.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_idx_reg <= m_tlast ? '0 : m_tdata[3:0] + 1'b1;
        end
    end

    `ZMPC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "result beat changed while stalled")

    `ZMPC_ASSERT_SAME(a_motor_order, m_tvalid,
        (m_tdata[3:0] == exp_idx_reg) &&
        (m_tlast == (m_tdata[3:0] == MOTOR_INDEX_W'(MOTOR_COUNT - 1))),
        "motor index out of sequence or last flag misplaced")

    `ZMPC_ASSERT_SAME(a_expired_silent, m_tvalid && !m_tdata[13],
        (m_tdata[11:4] == 8'd0) && !m_tdata[12],
        "motor driven or session running while outputs disabled")

    `ZMPC_ASSERT_SAME(a_minutes_range, m_tvalid,
        (m_tdata[28:22] >= 7'(MINUTES_MIN)) && (m_tdata[28:22] <= 7'(MINUTES_MAX)),
        "session length outside 5 to 120 minutes")

endmodule

bind zoned_motor_pattern_controller_unit zmpc_checker u_zmpc_checker (.*);

`default_nettype wire

// File: dv/zoned_motor_pattern_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Zoned motor pattern controller testbench
// Streams bed commands and millisecond ticks into the controller, predicts the
// ten per-motor result beats of every input beat with a behavioral model of
// the drive levels, presets and session timer, and compares them field by
// field while both channels stall at random and the bed address is changed.
// ----------------------------------------------------------------------------
module zoned_motor_pattern_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import zmpc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    // The slowest legal run has every result beat waiting out the longest
    // receiver stall and every input beat the longest sender gap, for at most
    // about two hundred input beats. The limit sits well above that.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int MAX_PRINTED_ERRORS = 100;

    // Command code the block does not define; it must change nothing.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    // First preset number that selects no pattern.
    localparam logic [7:0] PRESET_UNKNOWN = 8'd3;

    // Pattern timing in ticks and drive levels in percent.
    localparam int WAVE_PERIOD   = 600;
    localparam int PULSE_PERIOD  = 500;
    localparam int RIPPLE_PERIOD = 450;
    localparam int STEP_READY    = 600;
    localparam logic [6:0] WAVE_PEAK_PCT = 7'd80;
    localparam logic [6:0] WAVE_NEAR_PCT = 7'd45;
    localparam logic [6:0] WAVE_FAR_PCT  = 7'd15;
    localparam logic [6:0] PULSE_ON_PCT  = 7'd70;
    localparam logic [6:0] RIPPLE_HI_PCT = 7'd70;
    localparam logic [6:0] RIPPLE_LO_PCT = 7'd10;

    // One input beat as the testbench sees it.
    typedef struct {
        logic [2:0] cmd;
        logic [7:0] bed;
        logic [7:0] target;
        logic [7:0] value;
    } bed_item_t;

    // One result beat: the state of a single motor after an input beat.
    typedef struct {
        logic [3:0] motor;
        logic [7:0] duty;
        logic       last;
        logic       running;
        logic       active;
        logic [7:0] preset;
        logic [6:0] minutes;
    } motor_report_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [7:0]           cfg_wdata = 8'd0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    zoned_motor_pattern_controller_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared testbench state.
    // ------------------------------------------------------------------------
    bed_item_t     items_to_send[$];      // beats waiting for the driver
    motor_report_t motor_reports_due[$];  // predicted result beats, oldest first
    bed_item_t     in_flight;             // beat currently offered on s_*

    int errors        = 0;
    int gap_pct       = 0;   // chance of a sender gap after each beat
    int stall_pct     = 0;   // chance per cycle that the receiver starts a stall
    int send_hold     = 0;
    int stall_left    = 0;
    int unsigned cycle_count = 0;

    // Coverage tallies for the closing summary.
    int commands_sent   = 0;
    int ticks_sent      = 0;
    int reports_checked = 0;
    int pattern_steps   = 0;
    int bed_writes      = 0;

    // ------------------------------------------------------------------------
    // Behavioral copy of the controller state.
    // ------------------------------------------------------------------------
    logic [7:0]  bed_addr_q;
    logic [6:0]  drive_pct [MOTOR_COUNT];
    logic [7:0]  preset_sel;
    logic [6:0]  minutes_len;
    logic        outputs_on;
    logic        session_live;
    logic [22:0] session_ticks;
    logic [9:0]  pattern_ticks;
    logic [3:0]  pattern_pos;

    function automatic void reset_bed_state();
        bed_addr_q = 8'd1;
        foreach (drive_pct[i]) drive_pct[i] = 7'd0;
        preset_sel    = PRESET_NONE;
        minutes_len   = 7'd10;
        outputs_on    = 1'b1;
        session_live  = 1'b1;
        session_ticks = '0;
        pattern_ticks = 10'(STEP_READY);
        pattern_pos   = '0;
    endfunction

    function automatic void open_session();
        session_live  = 1'b1;
        outputs_on    = 1'b1;
        session_ticks = '0;
    endfunction

    // Advance the active preset by one tick. The counter saturates at the
    // ready value, so a freshly started preset steps on its first tick.
    function automatic void advance_pattern();
        int period;
        int gap_to_peak;
        case (preset_sel)
            PRESET_WAVE:   period = WAVE_PERIOD;
            PRESET_PULSE:  period = PULSE_PERIOD;
            PRESET_RIPPLE: period = RIPPLE_PERIOD;
            default:       return;
        endcase
        if (pattern_ticks < 10'(STEP_READY)) pattern_ticks = pattern_ticks + 1'b1;
        if (int'(pattern_ticks) < period) return;
        pattern_ticks = '0;
        pattern_steps++;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (preset_sel == PRESET_WAVE) begin
                gap_to_peak = (i > pattern_pos) ? i - pattern_pos : pattern_pos - i;
                drive_pct[i] = (gap_to_peak == 0) ? WAVE_PEAK_PCT :
                               (gap_to_peak == 1) ? WAVE_NEAR_PCT : WAVE_FAR_PCT;
            end else if (preset_sel == PRESET_PULSE) begin
                drive_pct[i] = pattern_pos[0] ? PULSE_ON_PCT : 7'd0;
            end else begin
                drive_pct[i] = (((i + pattern_pos) % 2) == 0) ? RIPPLE_HI_PCT : RIPPLE_LO_PCT;
            end
        end
        if (preset_sel == PRESET_WAVE) begin
            if (int'(pattern_pos) + 1 >= MOTOR_COUNT) begin
                pattern_pos = '0;
            end else begin
                pattern_pos = pattern_pos + 1'b1;
            end
        end else begin
            pattern_pos = {3'b000, ~pattern_pos[0]};
        end
    endfunction

    // Apply one accepted input beat to the state copy and queue the ten
    // result beats it must produce.
    function automatic void update_bed_state(input bed_item_t it);
        logic [6:0]    pct;
        motor_report_t rep;
        pct = (it.value > 8'd100) ? 7'd100 : it.value[6:0];
        if (it.cmd == CMD_TICK) begin
            ticks_sent++;
            if (outputs_on && preset_sel != PRESET_NONE) advance_pattern();
            if (session_live) begin
                session_ticks = session_ticks + 1'b1;
                if (int'(session_ticks) >= int'(minutes_len) * TICKS_PER_MINUTE) begin
                    outputs_on   = 1'b0;
                    session_live = 1'b0;
                    foreach (drive_pct[i]) drive_pct[i] = 7'd0;
                end
            end
        end else begin
            commands_sent++;
            if (it.bed == bed_addr_q) begin
                case (it.cmd)
                    CMD_OFF: begin
                        preset_sel = PRESET_NONE;
                        foreach (drive_pct[i]) drive_pct[i] = 7'd0;
                        session_live = 1'b0;
                        outputs_on   = 1'b1;
                    end
                    CMD_ALL: begin
                        preset_sel = PRESET_NONE;
                        foreach (drive_pct[i]) drive_pct[i] = pct;
                        open_session();
                    end
                    CMD_PAIR: begin
                        if (int'(it.target) < MOTOR_COUNT / 2) begin
                            preset_sel = PRESET_NONE;
                            drive_pct[2 * it.target]     = pct;
                            drive_pct[2 * it.target + 1] = pct;
                            open_session();
                        end
                    end
                    CMD_SINGLE: begin
                        if (int'(it.target) < MOTOR_COUNT) begin
                            preset_sel = PRESET_NONE;
                            drive_pct[it.target] = pct;
                            open_session();
                        end
                    end
                    CMD_PATTERN: begin
                        preset_sel    = it.target;
                        pattern_pos   = '0;
                        pattern_ticks = 10'(STEP_READY);
                        open_session();
                    end
                    CMD_SESSION: begin
                        minutes_len = (it.value < 8'd5)   ? 7'd5   :
                                      (it.value > 8'd120) ? 7'd120 : it.value[6:0];
                        if (session_live) session_ticks = '0;
                    end
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            rep.motor   = 4'(i);
            rep.duty    = 8'((int'(drive_pct[i]) * 255) / 100);
            rep.last    = (i == MOTOR_COUNT - 1);
            rep.running = session_live;
            rep.active  = outputs_on;
            rep.preset  = preset_sel;
            rep.minutes = minutes_len;
            motor_reports_due.push_back(rep);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking helpers. Printing stops after a hundred failures so a badly
    // broken block cannot flood the log; every failure is still counted.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_PRINTED_ERRORS)
                $error("%s expected %0d actual %0d", name, want, got);
        end
    endfunction

    function automatic void check_report();
        motor_report_t want;
        if (motor_reports_due.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTED_ERRORS)
                $error("result beat for motor %0d arrived with nothing outstanding",
                       m_tdata[3:0]);
            return;
        end
        want = motor_reports_due.pop_front();
        reports_checked++;
        check_field("motor_index",     want.motor,   m_tdata[3:0]);
        check_field("duty",            want.duty,    m_tdata[11:4]);
        check_field("session_running", want.running, m_tdata[12]);
        check_field("output_active",   want.active,  m_tdata[13]);
        check_field("active_preset",   want.preset,  m_tdata[21:14]);
        check_field("session_minutes", want.minutes, m_tdata[28:22]);
        check_field("tdata_pad",       0,            m_tdata[31:29]);
        check_field("last_motor",      want.last,    m_tlast);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. A beat is taken at an edge where s_tvalid and s_tready are
    // both high; the model is updated right there. The next beat, or a gap,
    // is set up in the same step with a single assignment per signal.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_hold = 0;
        end else begin
            if (s_tvalid && s_tready) update_bed_state(in_flight);
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    in_flight = items_to_send.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {in_flight.value, in_flight.target, in_flight.bed};
                    s_tuser   <= in_flight.cmd;
                    send_hold = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each beat taken on the result channel is checked
    // against the oldest prediction; m_tready drops for random stretches.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_report();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("zoned_motor_pattern_controller_unit_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [2:0] cmd, input logic [7:0] bed,
                             input logic [7:0] target, input logic [7:0] value);
        bed_item_t it;
        it.cmd    = cmd;
        it.bed    = bed;
        it.target = target;
        it.value  = value;
        items_to_send.push_back(it);
    endtask

    // Ticks carry random bed, target and value bytes, which the block ignores.
    task automatic push_ticks(input int count);
        for (int n = 0; n < count; n++)
            push_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Sampled on the falling edge so the driver and monitor have settled.
    // Returns once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        do @(negedge aclk);
        while (items_to_send.size() != 0 || s_tvalid || motor_reports_due.size() != 0);
    endtask

    // Only called while idle; the model takes the new address with the write.
    task automatic write_bed_address(input logic [7:0] addr);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        bed_addr_q = addr;
        bed_writes++;
        @(negedge aclk);
    endtask

    // Short directed run against the bed address left by reset: level
    // clamping, zone and motor limits, wrong bed, the unused command code,
    // minute clamping, the first step of each preset and the unknown presets.
    task automatic queue_directed();
        logic [7:0] b;
        b = bed_addr_q;
        push_item(CMD_TICK,    8'h00, 8'h00, 8'h00);
        push_item(CMD_ALL,     b, 8'h00, 8'hFF);
        push_item(CMD_PAIR,    b, 8'd4, 8'd100);
        push_item(CMD_PAIR,    b, 8'd5, 8'd50);
        push_item(CMD_SINGLE,  b, 8'd0, 8'd0);
        push_item(CMD_SINGLE,  b, 8'd9, 8'd101);
        push_item(CMD_SINGLE,  b, 8'd10, 8'd30);
        push_item(CMD_SINGLE,  b, 8'hFF, 8'd30);
        push_item(CMD_ALL,     ~b, 8'h00, 8'd50);
        push_item(CMD_UNUSED,  b, 8'h00, 8'd50);
        push_item(CMD_SESSION, b, 8'h00, 8'd0);
        push_item(CMD_SESSION, b, 8'h00, 8'hFF);
        push_item(CMD_SESSION, b, 8'h00, 8'd121);
        push_item(CMD_PATTERN, b, PRESET_WAVE, 8'h00);
        push_item(CMD_TICK,    8'hFF, 8'hFF, 8'hFF);
        push_item(CMD_TICK,    8'h00, 8'h00, 8'h00);
        push_item(CMD_PATTERN, b, PRESET_PULSE, 8'h00);
        push_item(CMD_TICK,    b, 8'h00, 8'h00);
        push_item(CMD_PATTERN, b, PRESET_RIPPLE, 8'hFF);
        push_item(CMD_TICK,    b, 8'h00, 8'h00);
        push_item(CMD_PATTERN, b, PRESET_UNKNOWN, 8'h00);
        push_item(CMD_TICK,    b, 8'h00, 8'h00);
        push_item(CMD_PATTERN, b, PRESET_NONE, 8'h00);
        push_item(CMD_TICK,    b, 8'h00, 8'h00);
        push_item(CMD_OFF,     b, 8'hFF, 8'hFF);
        push_item(CMD_SESSION, b, 8'h00, 8'd5);
        push_item(CMD_PAIR,    b, 8'd0, 8'd120);
    endtask

    // One random sequence: usually a well-formed command to this bed, otherwise a
    // noise beat, followed in either case by up to four ticks.
    task automatic queue_random_sequence();
        int         roll;
        int         burst;
        logic [7:0] level;
        level = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 100)) : 8'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                push_item(CMD_PATTERN, bed_addr_q,
                          ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 255))
                                                      : 8'($urandom_range(0, 2)),
                          8'($urandom));
            end else if (roll < 45) begin
                push_item(CMD_ALL, bed_addr_q, 8'($urandom), level);
            end else if (roll < 60) begin
                push_item(CMD_PAIR, bed_addr_q, 8'($urandom_range(0, MOTOR_COUNT / 2 - 1)),
                          level);
            end else if (roll < 75) begin
                push_item(CMD_SINGLE, bed_addr_q, 8'($urandom_range(0, MOTOR_COUNT - 1)),
                          level);
            end else if (roll < 88) begin
                push_item(CMD_SESSION, bed_addr_q, 8'($urandom),
                          $urandom_range(0, 1) ? 8'($urandom_range(0, 130)) : 8'($urandom));
            end else begin
                push_item(CMD_OFF, bed_addr_q, 8'($urandom), 8'($urandom));
            end
        end else begin
            // Noise: any code, often the wrong bed, any bytes.
            push_item(3'($urandom), $urandom_range(0, 1) ? bed_addr_q : 8'($urandom),
                      8'($urandom), 8'($urandom));
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) burst = $urandom_range(1, 4);
        else           burst = $urandom_range(0, 2);
        push_ticks(burst);
    endtask

    // A stretch of random sequences, with an occasional full drain in which
    // the sender holds off until every predicted beat has arrived.
    task automatic run_random_phase(input int sequences);
        for (int n = 0; n < sequences; n++) begin
            queue_random_sequence();
            if ($urandom_range(0, 11) == 0) wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        reset_bed_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed checks against the reset bed address, moderate idling.
        gap_pct   = 30;
        stall_pct = 15;
        queue_directed();
        wait_idle();

        // Lowest bed address, normal idling.
        write_bed_address(8'h00);
        run_random_phase(10);
        wait_idle();

        // Highest bed address under heavy back-pressure and sparse input.
        write_bed_address(8'hFF);
        gap_pct   = 60;
        stall_pct = 40;
        run_random_phase(10);
        wait_idle();

        // A middle address. First a short stretch with no idling at all that
        // starts each preset and takes its first step, then normal random
        // traffic.
        write_bed_address(8'($urandom_range(2, 254)));
        gap_pct   = 0;
        stall_pct = 0;
        push_item(CMD_PATTERN, bed_addr_q, PRESET_WAVE, 8'h00);
        push_ticks(3);
        push_item(CMD_PATTERN, bed_addr_q, PRESET_RIPPLE, 8'h00);
        push_ticks(3);
        push_item(CMD_PATTERN, bed_addr_q, PRESET_PULSE, 8'h00);
        push_ticks(3);
        wait_idle();
        gap_pct   = 30;
        stall_pct = 15;
        run_random_phase(10);

        // Drain, then allow the serializer's latency for any stray beat.
        wait_idle();
        repeat (30) @(posedge aclk);
        if (motor_reports_due.size() != 0) begin
            errors++;
            $error("%0d predicted result beats never arrived", motor_reports_due.size());
        end

        $display("Covered %0d command beats and %0d tick beats over %0d bed address writes,",
                 commands_sent, ticks_sent, bed_writes);
        $display("checking %0d result beats across %0d pattern steps.",
                 reports_checked, pattern_steps);
        if (errors == 0) begin
            $display("zoned_motor_pattern_controller_unit_tb: clean");
        end else begin
            $display("zoned_motor_pattern_controller_unit_tb: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/zmpc_pkg.sv
rtl/zmpc_front.sv
rtl/zmpc_queue.sv
rtl/zmpc_back.sv
rtl/zoned_motor_pattern_controller_unit.sv
rtl/zmpc_checker.sv
dv/zoned_motor_pattern_controller_unit_tb.sv
